[rtl/core/tsyn_pkg.sv]
// Shared types, constants and checksum helpers for the TCP SYN header builder.
// No dependencies; imported by every module under rtl/core.
package tsyn_pkg;

    localparam int WORDS_PER_HDR = 20;
    localparam int WORD_IDX_W    = 5;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ADDRESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PORT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_NUMBER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_TO_LIVE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE     = 3'd4;

    // Register reset values
    localparam logic [31:0] RST_SOURCE_ADDRESS  = 32'd0;
    localparam logic [15:0] RST_SOURCE_PORT     = 16'd5132;
    localparam logic [31:0] RST_SEQUENCE_NUMBER = 32'd167273;
    localparam logic [7:0]  RST_TIME_TO_LIVE    = 8'd128;
    localparam logic [15:0] RST_WINDOW_SIZE     = 16'hffff;

    // Fixed header words
    localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
    localparam logic [15:0] IP_TOTAL_LEN   = 16'h0028;
    localparam logic [15:0] IP_ID          = 16'h0000;
    localparam logic [15:0] IP_FLAGS_DF    = 16'h4000;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [15:0] TCP_LEN        = 16'd20;
    localparam logic [15:0] TCP_OFF_FLAGS  = 16'h5002;

    // Word positions that carry the checksums
    localparam logic [WORD_IDX_W-1:0] WORD_IP_CSUM  = 5'd5;
    localparam logic [WORD_IDX_W-1:0] WORD_TCP_CSUM = 5'd18;
    localparam logic [WORD_IDX_W-1:0] WORD_LAST     = 5'(WORDS_PER_HDR - 1);

    typedef struct packed {
        logic [31:0] dest_address;
        logic [15:0] dest_port;
    } in_beat_t;

    typedef struct packed {
        logic [15:0]           header_word;
        logic [WORD_IDX_W-1:0] word_index;
        logic                  last_word;
    } out_beat_t;

    typedef struct packed {
        logic [31:0] source_address;
        logic [15:0] source_port;
        logic [31:0] sequence_number;
        logic [7:0]  time_to_live;
        logic [15:0] window_size;
    } cfg_t;

    // Finished checksum result handed to the serializer
    typedef struct packed {
        logic [31:0] dest_address;
        logic [15:0] dest_port;
        logic [15:0] ip_check;
        logic [15:0] tcp_check;
    } hdr_item_t;

    // One end-around carry fold of a 20-bit sum
    function automatic logic [16:0] fold20(input logic [19:0] sum);
        return {1'b0, sum[15:0]} + {13'd0, sum[19:16]};
    endfunction

    // Final fold of a 17-bit value and ones' complement
    function automatic logic [15:0] fold_final(input logic [16:0] sum);
        logic [15:0] s;
        s = sum[15:0] + {15'd0, sum[16]};
        return ~s;
    endfunction

endpackage

[rtl/core/tsyn_csum_pipe.sv]
// Three-stage checksum pipeline: partial sums, combine and fold, final fold.
// Depends on tsyn_pkg.
module tsyn_csum_pipe import tsyn_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output hdr_item_t out_data
);

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic        s1_adv, s2_adv, s3_adv;
    in_beat_t    s1_beat_reg, s2_beat_reg;
    logic [17:0] s1_addr_sum_reg;
    logic [16:0] s1_ip_rest_reg;
    logic [18:0] s1_tcp_rest_reg;
    logic [16:0] s2_ip_fold_reg, s2_tcp_fold_reg;
    hdr_item_t   s3_item_reg;
    logic [19:0] ip_sum, tcp_sum;

    // Stage handshakes: a stage moves on when the next one is empty or moving
    assign s3_adv    = !s3_valid_reg || out_ready;
    assign s2_adv    = !s2_valid_reg || s3_adv;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign in_ready  = s1_adv;
    assign out_valid = s3_valid_reg;
    assign out_data  = s3_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s1_adv) s1_valid_reg <= in_valid;
            if (s2_adv) s2_valid_reg <= s1_valid_reg;
            if (s3_adv) s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 1: address words shared by both sums, plus the remaining fields
    always_ff @(posedge aclk) begin
        if (s1_adv && in_valid) begin
            s1_beat_reg     <= in_data;
            s1_addr_sum_reg <= {2'd0, cfg.source_address[31:16]}
                             + {2'd0, cfg.source_address[15:0]}
                             + {2'd0, in_data.dest_address[31:16]}
                             + {2'd0, in_data.dest_address[15:0]};
            s1_ip_rest_reg  <= {1'b0, IP_VER_IHL_TOS} + {1'b0, IP_TOTAL_LEN}
                             + {1'b0, IP_ID} + {1'b0, IP_FLAGS_DF}
                             + {1'b0, cfg.time_to_live, PROTO_TCP};
            s1_tcp_rest_reg <= {11'd0, PROTO_TCP} + {3'd0, TCP_LEN}
                             + {3'd0, TCP_OFF_FLAGS}
                             + {3'd0, cfg.source_port} + {3'd0, in_data.dest_port}
                             + {3'd0, cfg.sequence_number[31:16]}
                             + {3'd0, cfg.sequence_number[15:0]}
                             + {3'd0, cfg.window_size};
        end
    end

    // Stage 2: complete sums and first carry fold
    assign ip_sum  = {2'd0, s1_addr_sum_reg} + {3'd0, s1_ip_rest_reg};
    assign tcp_sum = {2'd0, s1_addr_sum_reg} + {1'b0, s1_tcp_rest_reg};

    always_ff @(posedge aclk) begin
        if (s2_adv && s1_valid_reg) begin
            s2_beat_reg     <= s1_beat_reg;
            s2_ip_fold_reg  <= fold20(ip_sum);
            s2_tcp_fold_reg <= fold20(tcp_sum);
        end
    end

    // Stage 3: last fold and complement
    always_ff @(posedge aclk) begin
        if (s3_adv && s2_valid_reg) begin
            s3_item_reg.dest_address <= s2_beat_reg.dest_address;
            s3_item_reg.dest_port    <= s2_beat_reg.dest_port;
            s3_item_reg.ip_check     <= fold_final(s2_ip_fold_reg);
            s3_item_reg.tcp_check    <= fold_final(s2_tcp_fold_reg);
        end
    end

endmodule

[rtl/core/tsyn_word_ser.sv]
// Header serializer: holds one finished header and sends its twenty words.
// Depends on tsyn_pkg.
module tsyn_word_ser import tsyn_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  hdr_item_t in_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic                  hold_valid_reg;
    hdr_item_t             hold_reg;
    logic [WORD_IDX_W-1:0] idx_reg, idx_next;
    logic                  out_valid_reg;
    out_beat_t             out_reg;
    logic                  out_load, last_load;
    logic [15:0]           words [WORDS_PER_HDR];

    assign out_load  = hold_valid_reg && (!out_valid_reg || m_ready);
    assign last_load = out_load && (idx_reg == WORD_LAST);
    assign in_ready  = !hold_valid_reg || last_load;
    assign idx_next  = last_load ? '0 : idx_reg + 5'd1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    // Header word table for the held item
    always_comb begin
        words[0]  = IP_VER_IHL_TOS;
        words[1]  = IP_TOTAL_LEN;
        words[2]  = IP_ID;
        words[3]  = IP_FLAGS_DF;
        words[4]  = {cfg.time_to_live, PROTO_TCP};
        words[5]  = hold_reg.ip_check;
        words[6]  = cfg.source_address[31:16];
        words[7]  = cfg.source_address[15:0];
        words[8]  = hold_reg.dest_address[31:16];
        words[9]  = hold_reg.dest_address[15:0];
        words[10] = cfg.source_port;
        words[11] = hold_reg.dest_port;
        words[12] = cfg.sequence_number[31:16];
        words[13] = cfg.sequence_number[15:0];
        words[14] = 16'd0;
        words[15] = 16'd0;
        words[16] = TCP_OFF_FLAGS;
        words[17] = cfg.window_size;
        words[18] = hold_reg.tcp_check;
        words[19] = 16'd0;
    end

    // Hold slot and word counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end else begin
            if (out_load) idx_reg <= idx_next;
            if (in_ready) hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) hold_reg <= in_data;
    end

    // Output register: next word loads when the current beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg.header_word <= words[idx_reg];
            out_reg.word_index  <= idx_reg;
            out_reg.last_word   <= (idx_reg == WORD_LAST);
        end
    end

endmodule

[rtl/core/tcp_syn_header_builder.sv]
// TCP SYN header builder: one request in, twenty 16-bit header words out.
// A request passes the checksum pipeline stages, the serializer hold slot and the
// output register before its first word shows on m_data. Throughput: one word per cycle
// while m_ready stays high; up to three further requests queue in the checksum pipeline.
// Reset (aresetn low, synchronous) empties all stages and restores registers.
module tcp_syn_header_builder import tsyn_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data
);

    cfg_t      cfg_reg;
    logic      pipe_valid, pipe_ready;
    hdr_item_t pipe_item;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_address  <= RST_SOURCE_ADDRESS;
            cfg_reg.source_port     <= RST_SOURCE_PORT;
            cfg_reg.sequence_number <= RST_SEQUENCE_NUMBER;
            cfg_reg.time_to_live    <= RST_TIME_TO_LIVE;
            cfg_reg.window_size     <= RST_WINDOW_SIZE;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SOURCE_ADDRESS:  cfg_reg.source_address  <= cfg_wdata;
                REG_SOURCE_PORT:     cfg_reg.source_port     <= cfg_wdata[15:0];
                REG_SEQUENCE_NUMBER: cfg_reg.sequence_number <= cfg_wdata;
                REG_TIME_TO_LIVE:    cfg_reg.time_to_live    <= cfg_wdata[7:0];
                REG_WINDOW_SIZE:     cfg_reg.window_size     <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    tsyn_csum_pipe u_csum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (pipe_valid),
        .out_ready (pipe_ready),
        .out_data  (pipe_item)
    );

    tsyn_word_ser u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (pipe_valid),
        .in_ready (pipe_ready),
        .in_data  (pipe_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

[tb/tcp_syn_header_builder_tb.sv]
// Self-checking testbench for tcp_syn_header_builder: directed table, then random requests.
// Predicts all twenty header words per request and checks each beat in order.
// Depends on tsyn_pkg and the tcp_syn_header_builder RTL only.
module tcp_syn_header_builder_tb;
    import tsyn_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_LIMIT   = 40;
    localparam int RAND_SEGMENTS = 6;
    localparam int RAND_PER_SEG  = 42;
    localparam int DRAIN_CYCLES  = 30;

    // indexes past the end of the register list, writes there are ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_MID   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef enum logic [0:0] {ROW_REQ, ROW_CFG} row_kind_t;

    // one line of the directed plan; checksums are only used when typed is set
    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] value;
        in_beat_t              req;
        logic                  typed;
        logic [15:0]           ip_csum;
        logic [15:0]           tcp_csum;
    } plan_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_beat_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_beat_t             m_data;

    cfg_t      shadow_cfg;
    out_beat_t header_words_due [$];
    plan_row_t plan [$];

    int errors;
    int cycles;
    int requests_sent;
    int words_checked;
    int reg_writes;
    int send_idle_pct;
    int recv_idle_pct;

    tcp_syn_header_builder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // end-around carry fold, then ones' complement
    function automatic logic [15:0] finish_checksum(logic [31:0] acc);
        while (acc[31:16] != 16'd0) begin
            acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
        end
        return ~acc[15:0];
    endfunction

    // Build the header for one request and queue its twenty beats
    function automatic void queue_syn_header(in_beat_t req, logic typed,
                                             logic [15:0] typed_ip, logic [15:0] typed_tcp);
        logic [15:0] w [WORDS_PER_HDR];
        logic [31:0] acc;
        logic [15:0] ip_sum;
        logic [15:0] tcp_sum;
        out_beat_t   b;
        w[0]  = IP_VER_IHL_TOS;
        w[1]  = IP_TOTAL_LEN;
        w[2]  = IP_ID;
        w[3]  = IP_FLAGS_DF;
        w[4]  = {shadow_cfg.time_to_live, PROTO_TCP};
        w[5]  = 16'd0;
        w[6]  = shadow_cfg.source_address[31:16];
        w[7]  = shadow_cfg.source_address[15:0];
        w[8]  = req.dest_address[31:16];
        w[9]  = req.dest_address[15:0];
        w[10] = shadow_cfg.source_port;
        w[11] = req.dest_port;
        w[12] = shadow_cfg.sequence_number[31:16];
        w[13] = shadow_cfg.sequence_number[15:0];
        w[14] = 16'd0;
        w[15] = 16'd0;
        w[16] = TCP_OFF_FLAGS;
        w[17] = shadow_cfg.window_size;
        w[18] = 16'd0;
        w[19] = 16'd0;

        acc = 32'd0;
        for (int k = 0; k < 10; k++) acc += {16'd0, w[k]};
        ip_sum = finish_checksum(acc);

        // pseudo-header: addresses, zero byte plus protocol, TCP length
        acc = {16'd0, w[6]} + {16'd0, w[7]} + {16'd0, w[8]} + {16'd0, w[9]}
            + {24'd0, PROTO_TCP} + {16'd0, TCP_LEN};
        for (int k = 10; k < WORDS_PER_HDR; k++) acc += {16'd0, w[k]};
        tcp_sum = finish_checksum(acc);

        w[WORD_IP_CSUM]  = typed ? typed_ip : ip_sum;
        w[WORD_TCP_CSUM] = typed ? typed_tcp : tcp_sum;

        for (int k = 0; k < WORDS_PER_HDR; k++) begin
            b.header_word = w[k];
            b.word_index  = WORD_IDX_W'(k);
            b.last_word   = (k == WORDS_PER_HDR - 1);
            header_words_due.push_back(b);
        end
    endfunction

    task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (errors < PRINT_LIMIT)
            $display("MISMATCH %s: got %h, want %h (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // Output beat checker
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (header_words_due.size() == 0) begin
                note_mismatch("unexpected beat", {10'd0, m_data}, 32'd0);
            end else begin
                want = header_words_due.pop_front();
                words_checked++;
                if (m_data.header_word !== want.header_word)
                    note_mismatch($sformatf("header_word[%0d]", want.word_index),
                                  {16'd0, m_data.header_word}, {16'd0, want.header_word});
                if (m_data.word_index !== want.word_index)
                    note_mismatch("word_index", {27'd0, m_data.word_index},
                                  {27'd0, want.word_index});
                if (m_data.last_word !== want.last_word)
                    note_mismatch("last_word", {31'd0, m_data.last_word},
                                  {31'd0, want.last_word});
            end
        end
    end

    // Timeout watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycles, header_words_due.size());
            $display("tcp_syn_header_builder verification failed");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_SOURCE_ADDRESS:  shadow_cfg.source_address  = value;
            REG_SOURCE_PORT:     shadow_cfg.source_port     = value[15:0];
            REG_SEQUENCE_NUMBER: shadow_cfg.sequence_number = value;
            REG_TIME_TO_LIVE:    shadow_cfg.time_to_live    = value[7:0];
            REG_WINDOW_SIZE:     shadow_cfg.window_size     = value[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        reg_writes++;
    endtask

    // drop valid and hold off until every header has come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (header_words_due.size() != 0);
    endtask

    // One request beat; returns at the falling edge after acceptance
    task automatic send_request(in_beat_t req, logic typed,
                                logic [15:0] typed_ip, logic [15:0] typed_tcp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        queue_syn_header(req, typed, typed_ip, typed_tcp);
        requests_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_word32();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic in_beat_t pick_request();
        in_beat_t r;
        r.dest_address = pick_word32();
        case ($urandom_range(0, 4))
            0: r.dest_port = 16'h0000;
            1: r.dest_port = 16'hffff;
            default: r.dest_port = 16'($urandom);
        endcase
        return r;
    endfunction

    // Stimulus
    initial begin
        plan_row_t row;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        errors        = 0;
        cycles        = 0;
        requests_sent = 0;
        words_checked = 0;
        reg_writes    = 0;
        send_idle_pct = 28;
        recv_idle_pct = 46;
        shadow_cfg = '{RST_SOURCE_ADDRESS, RST_SOURCE_PORT, RST_SEQUENCE_NUMBER,
                       RST_TIME_TO_LIVE, RST_WINDOW_SIZE};

        // reset values: checksums worked out by hand
        plan.push_back('{ROW_REQ, REG_SOURCE_ADDRESS, 32'd0, {32'h0000_0000, 16'h0000},
                         1'b1, 16'hfad0, 16'h0e6c});
        // all-ones destination is neutral in ones' complement, same checksums
        plan.push_back('{ROW_REQ, REG_SOURCE_ADDRESS, 32'd0, {32'hffff_ffff, 16'hffff},
                         1'b1, 16'hfad0, 16'h0e6c});
        // sums land on 0xffff so both checksums go out as zero
        plan.push_back('{ROW_REQ, REG_SOURCE_ADDRESS, 32'd0, {32'h0000_fad0, 16'h139b},
                         1'b1, 16'h0000, 16'h0000});
        plan.push_back('{ROW_REQ, REG_SOURCE_ADDRESS, 32'd0, {32'h8000_0001, 16'h8001},
                         1'b0, 16'h0, 16'h0});
        // every register at zero
        plan.push_back('{ROW_CFG, REG_SOURCE_ADDRESS,  32'd0, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_CFG, REG_SOURCE_PORT,     32'd0, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_CFG, REG_SEQUENCE_NUMBER, 32'd0, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_CFG, REG_TIME_TO_LIVE,    32'd0, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_CFG, REG_WINDOW_SIZE,     32'd0, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_REQ, REG_SOURCE_ADDRESS, 32'd0, {32'h0000_0000, 16'h0000},
                         1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_REQ, REG_SOURCE_ADDRESS, 32'd0, {32'hffff_ffff, 16'hffff},
                         1'b0, 16'h0, 16'h0});
        // every register at its maximum, written with all 32 bits set
        plan.push_back('{ROW_CFG, REG_SOURCE_ADDRESS,  32'hffff_ffff, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_CFG, REG_SOURCE_PORT,     32'hffff_ffff, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_CFG, REG_SEQUENCE_NUMBER, 32'hffff_ffff, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_CFG, REG_TIME_TO_LIVE,    32'hffff_ffff, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_CFG, REG_WINDOW_SIZE,     32'hffff_ffff, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_REQ, REG_SOURCE_ADDRESS, 32'd0, {32'h0000_0000, 16'h0000},
                         1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_REQ, REG_SOURCE_ADDRESS, 32'd0, {32'hffff_ffff, 16'hffff},
                         1'b0, 16'h0, 16'h0});
        // writes past the register list must leave the all-ones setting alone
        plan.push_back('{ROW_CFG, REG_SPARE_FIRST, 32'd0, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_CFG, REG_SPARE_MID,   32'd0, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_CFG, REG_SPARE_LAST,  32'd0, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_REQ, REG_SOURCE_ADDRESS, 32'd0, {32'h1234_5678, 16'h0050},
                         1'b0, 16'h0, 16'h0});
        // mixed setting; upper bits of the narrow registers get masked
        plan.push_back('{ROW_CFG, REG_SOURCE_ADDRESS,  32'hc0a8_0001, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_CFG, REG_SOURCE_PORT,     32'h5a5a_8000, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_CFG, REG_SEQUENCE_NUMBER, 32'h7fff_ffff, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_CFG, REG_TIME_TO_LIVE,    32'habcd_ef40, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_CFG, REG_WINDOW_SIZE,     32'hdead_0001, 48'd0, 1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_REQ, REG_SOURCE_ADDRESS, 32'd0, {32'h0a00_0001, 16'd443},
                         1'b0, 16'h0, 16'h0});
        plan.push_back('{ROW_REQ, REG_SOURCE_ADDRESS, 32'd0, {32'h55aa_55aa, 16'haa55},
                         1'b0, 16'h0, 16'h0});

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table
        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                write_register(row.idx, row.value);
            end else begin
                send_request(row.req, row.typed, row.ip_csum, row.tcp_csum);
            end
        end

        // Random segments: two per idling profile, fresh registers for each
        for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
            case (seg / 2)
                0: begin send_idle_pct = 28; recv_idle_pct = 46; end
                1: begin send_idle_pct = 46; recv_idle_pct = 28; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            wait_idle();
            write_register(REG_SOURCE_ADDRESS,  pick_word32());
            write_register(REG_SOURCE_PORT,     pick_word32());
            write_register(REG_SEQUENCE_NUMBER, pick_word32());
            write_register(REG_TIME_TO_LIVE,    pick_word32());
            write_register(REG_WINDOW_SIZE,     pick_word32());
            write_register(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                           pick_word32());
            for (int n = 0; n < RAND_PER_SEG; n++) begin
                // sender holds off mid-segment until the pipeline is empty
                if (n == RAND_PER_SEG / 2)
                    wait_idle();
                send_request(pick_request(), 1'b0, 16'h0, 16'h0);
            end
        end

        // Drain
        s_valid <= 1'b0;
        while (header_words_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("ran %0d SYN requests, %0d header words checked, %0d register writes",
                 requests_sent, words_checked, reg_writes);
        $display("idling profiles: sender-heavy, receiver-heavy and none; %0d mismatches",
                 errors);
        if (errors == 0) begin
            $display("tcp_syn_header_builder verification clean");
        end else begin
            $display("tcp_syn_header_builder verification failed");
        end
        $finish;
    end

endmodule
